// ----- hdl/dmtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dmtt_pkg
// Shared constants, types and the mate score helper for the direct-mapped
// transposition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmtt_pkg;

    localparam int MAX_ENTRIES    = 1024;
    localparam int SLOT_BITS      = $clog2(MAX_ENTRIES);
    localparam int ENTRIES_BITS   = SLOT_BITS + 1;
    localparam int KEY_BITS       = 64;
    localparam int SCORE_BITS     = 16;
    localparam int SCORE_EXT_BITS = SCORE_BITS + 2;
    localparam int BOUNDARY_BITS  = 15;
    localparam int PLY_BITS       = 8;
    localparam int DEPTH_BITS     = 8;
    localparam int MOVE_BITS      = 16;
    localparam int BOUND_BITS     = 2;
    localparam int KIND_BITS      = 2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;

    localparam int DIGIT_BITS     = 4;
    localparam int MOD_STEPS      = KEY_BITS / DIGIT_BITS;
    localparam int STEP_CNT_BITS  = $clog2(MOD_STEPS);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRIES  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUNDARY = 2'd1;

    localparam logic [ENTRIES_BITS-1:0]  ENTRIES_RESET  = ENTRIES_BITS'(MAX_ENTRIES);
    localparam logic [BOUNDARY_BITS-1:0] BOUNDARY_RESET = BOUNDARY_BITS'(30000);

    localparam logic [KIND_BITS-1:0] KIND_PROBE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_STORE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [SCORE_EXT_BITS-1:0] SCORE_HI =
        SCORE_EXT_BITS'((1 << (SCORE_BITS - 1)) - 1);
    localparam logic signed [SCORE_EXT_BITS-1:0] SCORE_LO =
        -SCORE_HI - SCORE_EXT_BITS'(1);

    typedef struct packed {
        logic [DEPTH_BITS-1:0]        depth;
        logic [MOVE_BITS-1:0]         move;
        logic signed [SCORE_BITS-1:0] score;
        logic [BOUND_BITS-1:0]        bound;
    } slot_data_t;

    typedef struct packed {
        logic                 wr_key;
        logic                 wr_data;
        logic                 rd;
        logic [SLOT_BITS-1:0] addr;
    } mem_cmd_t;

    // away = 1 pushes mate scores away from zero, away = 0 pulls them in
    function automatic logic signed [SCORE_BITS-1:0] mate_shift(
        input logic signed [SCORE_BITS-1:0] s,
        input logic [PLY_BITS-1:0]          ply,
        input logic [BOUNDARY_BITS-1:0]     bnd,
        input logic                         away
    );
        logic signed [SCORE_EXT_BITS-1:0] sx;
        logic signed [SCORE_EXT_BITS-1:0] bx;
        logic signed [SCORE_EXT_BITS-1:0] px;
        logic signed [SCORE_EXT_BITS-1:0] sum;
        logic signed [SCORE_BITS-1:0]     res;
        sx = {{(SCORE_EXT_BITS - SCORE_BITS){s[SCORE_BITS-1]}}, s};
        bx = SCORE_EXT_BITS'(bnd);
        px = SCORE_EXT_BITS'(ply);
        if (sx > bx)
        begin
            sum = away ? (sx + px) : (sx - px);
        end
        else if (sx < -bx)
        begin
            sum = away ? (sx - px) : (sx + px);
        end
        else
        begin
            sum = sx;
        end
        if (sum > SCORE_HI)
        begin
            res = SCORE_HI[SCORE_BITS-1:0];
        end
        else if (sum < SCORE_LO)
        begin
            res = SCORE_LO[SCORE_BITS-1:0];
        end
        else
        begin
            res = sum[SCORE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dmtt_mod_unit.sv -----
// ----------------------------------------------------------------------------
// dmtt_mod_unit
// Iterative remainder of the 64-bit key by the slot count, DIGIT_BITS key
// bits per cycle through a chain of compare and subtract steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmtt_mod_unit import dmtt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [KEY_BITS-1:0]     key,
    input  wire logic [ENTRIES_BITS-1:0] modulus,
    output logic                         done,
    output logic [SLOT_BITS-1:0]         rem
);

    logic [KEY_BITS-1:0]      key_sh_reg;
    logic [KEY_BITS-1:0]      key_sh_next;
    logic [SLOT_BITS-1:0]     rem_reg;
    logic [SLOT_BITS-1:0]     rem_next;
    logic [STEP_CNT_BITS-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [SLOT_BITS:0]       trial;
    logic                     last_step;

    assign last_step   = (cnt_reg == STEP_CNT_BITS'(MOD_STEPS - 1));
    assign key_sh_next = key_sh_reg << DIGIT_BITS;

    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial = {rem_next, key_sh_reg[KEY_BITS-1-i]};
            if (trial >= modulus)
            begin
                trial = trial - modulus;
            end
            rem_next = trial[SLOT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_sh_reg <= key;
            rem_reg    <= '0;
        end
        else if (busy_reg)
        begin
            key_sh_reg <= key_sh_next;
            rem_reg    <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- hdl/dmtt_slot_mem.sv -----
// ----------------------------------------------------------------------------
// dmtt_slot_mem
// Slot storage: a key array and a data array with separate write enables
// and a shared registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmtt_slot_mem import dmtt_pkg::*;
(
    input  wire logic                clk,
    input  wire mem_cmd_t            cmd,
    input  wire logic [KEY_BITS-1:0] wr_key,
    input  wire slot_data_t          wr_data,
    output logic [KEY_BITS-1:0]      rd_key,
    output slot_data_t               rd_data
);

    logic [KEY_BITS-1:0] key_mem [0:MAX_ENTRIES-1];
    slot_data_t          data_mem [0:MAX_ENTRIES-1];
    logic [KEY_BITS-1:0] rd_key_reg;
    slot_data_t          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_key)
        begin
            key_mem[cmd.addr] <= wr_key;
        end
        if (cmd.wr_data)
        begin
            data_mem[cmd.addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_key_reg  <= key_mem[cmd.addr];
            rd_data_reg <= data_mem[cmd.addr];
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/direct_mapped_transposition_table.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_transposition_table
// Direct-mapped hash table of search results with mate score ply adjustment.
// Probe and store wait for the slot index from the remainder unit, 4 key
// bits per cycle; a probe then reads the slot and responds once the output
// register is free. The next request is taken only once the last is through.
// Clear: one key slot zeroed per cycle.
// After reset a pass zeroes every slot; requests wait until done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_transposition_table import dmtt_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_en,
    input  wire logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire logic [KIND_BITS-1:0]          kind,
    input  wire logic [KEY_BITS-1:0]           position_key,
    input  wire logic [PLY_BITS-1:0]           ply,
    input  wire logic [DEPTH_BITS-1:0]         search_depth,
    input  wire logic [MOVE_BITS-1:0]          search_move,
    input  wire logic signed [SCORE_BITS-1:0]  search_score,
    input  wire logic [BOUND_BITS-1:0]         bound_kind,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output logic                               hit,
    output logic [DEPTH_BITS-1:0]              found_depth,
    output logic [MOVE_BITS-1:0]               found_move,
    output logic signed [SCORE_BITS-1:0]       found_score,
    output logic [BOUND_BITS-1:0]              found_bound
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [SLOT_BITS-1:0]     idx_reg;
    logic [ENTRIES_BITS-1:0]  entries_reg;
    logic [BOUNDARY_BITS-1:0] boundary_reg;
    logic [ENTRIES_BITS-1:0]  eff_mod;

    logic [KIND_BITS-1:0]     kind_reg;
    logic [KEY_BITS-1:0]      key_reg;
    logic [PLY_BITS-1:0]      ply_reg;
    slot_data_t               in_data_reg;

    logic                     rsp_valid_reg;
    logic                     hit_reg;
    slot_data_t               found_reg;

    logic                     accept;
    logic                     mod_done;
    logic [SLOT_BITS-1:0]     mod_rem;
    logic                     sweep_last;
    logic                     rsp_load;
    logic                     key_match;
    mem_cmd_t                 mem_cmd;
    logic [KEY_BITS-1:0]      mem_wr_key;
    slot_data_t               mem_wr_data;
    logic [KEY_BITS-1:0]      mem_rd_key;
    slot_data_t               mem_rd_data;
    slot_data_t               probe_data;

    assign req_ready  = (state_reg == ST_IDLE);
    assign accept     = req_valid && req_ready;
    assign sweep_last = (idx_reg == SLOT_BITS'(MAX_ENTRIES - 1));
    assign rsp_load   = (state_reg == ST_CMP) && (!rsp_valid_reg || rsp_ready);
    assign key_match  = (mem_rd_key == key_reg);

    always_comb
    begin
        if (entries_reg == '0)
        begin
            eff_mod = ENTRIES_BITS'(1);
        end
        else if (entries_reg > ENTRIES_BITS'(MAX_ENTRIES))
        begin
            eff_mod = ENTRIES_BITS'(MAX_ENTRIES);
        end
        else
        begin
            eff_mod = entries_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg  <= ENTRIES_RESET;
            boundary_reg <= BOUNDARY_RESET;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_ENTRIES:  entries_reg  <= cfg_data[ENTRIES_BITS-1:0];
                CFG_BOUNDARY: boundary_reg <= cfg_data[BOUNDARY_BITS-1:0];
                default:      ;
            endcase
        end
    end

    dmtt_mod_unit u_mod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && (kind == KIND_PROBE || kind == KIND_STORE)),
        .key     (position_key),
        .modulus (eff_mod),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_PROBE, KIND_STORE: state_next = ST_MOD;
                        KIND_CLEAR:             state_next = ST_SWEEP;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = (kind_reg == KIND_STORE) ? ST_IDLE : ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT || state_reg == ST_SWEEP)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else
            begin
                idx_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg          <= kind;
            key_reg           <= position_key;
            ply_reg           <= ply;
            in_data_reg.depth <= search_depth;
            in_data_reg.move  <= search_move;
            in_data_reg.score <= search_score;
            in_data_reg.bound <= bound_kind;
        end
    end

    always_comb
    begin
        mem_cmd.wr_key  = 1'b0;
        mem_cmd.wr_data = 1'b0;
        mem_cmd.rd      = 1'b0;
        mem_cmd.addr    = mod_rem;
        mem_wr_key      = key_reg;
        mem_wr_data     = in_data_reg;
        mem_wr_data.score = mate_shift(in_data_reg.score, ply_reg, boundary_reg, 1'b1);
        unique case (state_reg)
            ST_INIT:
            begin
                mem_cmd.wr_key  = 1'b1;
                mem_cmd.wr_data = 1'b1;
                mem_cmd.addr    = idx_reg;
                mem_wr_key      = '0;
                mem_wr_data     = '0;
            end
            ST_SWEEP:
            begin
                mem_cmd.wr_key = 1'b1;
                mem_cmd.addr   = idx_reg;
                mem_wr_key     = '0;
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    if (kind_reg == KIND_STORE)
                    begin
                        mem_cmd.wr_key  = 1'b1;
                        mem_cmd.wr_data = 1'b1;
                    end
                    else
                    begin
                        mem_cmd.rd = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    dmtt_slot_mem u_mem
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .wr_key  (mem_wr_key),
        .wr_data (mem_wr_data),
        .rd_key  (mem_rd_key),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        probe_data       = mem_rd_data;
        probe_data.score = mate_shift(mem_rd_data.score, ply_reg, boundary_reg, 1'b0);
        if (!key_match)
        begin
            probe_data = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            hit_reg   <= key_match;
            found_reg <= probe_data;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign hit         = hit_reg;
    assign found_depth = found_reg.depth;
    assign found_move  = found_reg.move;
    assign found_score = found_reg.score;
    assign found_bound = found_reg.bound;

    // remainder unit finishes only for a probe or store in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("remainder done outside of index phase");

    // slot index stays below the slot count in use
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> ({1'b0, mod_rem} < eff_mod))
        else $error("slot index out of range");

    // a new response only follows a compare cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && !rsp_valid_reg) |=> (rsp_valid_reg && $past(kind_reg) == KIND_PROBE))
        else $error("response from a non-probe request");

    // sweeps advance one slot per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && !sweep_last) |=>
        (state_reg == ST_SWEEP && idx_reg == $past(idx_reg) + 1'b1))
        else $error("key clear sweep skipped a slot");

endmodule

`default_nettype wire

// ----- test/dmtt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmtt_checker
// Follows the configuration writes and the request channel of the
// transposition table, keeps its own copy of every slot, works out the
// response of each probe and compares it field by field with the response
// channel. Mismatch and progress counts go to the testbench top.
// ----------------------------------------------------------------------------

module dmtt_checker import dmtt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_en,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic [KIND_BITS-1:0]         kind,
    input  logic [KEY_BITS-1:0]          position_key,
    input  logic [PLY_BITS-1:0]          ply,
    input  logic [DEPTH_BITS-1:0]        search_depth,
    input  logic [MOVE_BITS-1:0]         search_move,
    input  logic signed [SCORE_BITS-1:0] search_score,
    input  logic [BOUND_BITS-1:0]        bound_kind,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic                         hit,
    input  logic [DEPTH_BITS-1:0]        found_depth,
    input  logic [MOVE_BITS-1:0]         found_move,
    input  logic signed [SCORE_BITS-1:0] found_score,
    input  logic [BOUND_BITS-1:0]        found_bound,
    output int                           mismatches,
    output int                           lookups_waiting,
    output int                           lookups_checked,
    output int                           hits_checked,
    output int                           stores_seen,
    output int                           clears_seen
);

    typedef struct packed {
        logic                         hit;
        logic [DEPTH_BITS-1:0]        depth;
        logic [MOVE_BITS-1:0]         move;
        logic signed [SCORE_BITS-1:0] score;
        logic [BOUND_BITS-1:0]        bound;
    } lookup_t;

    logic [KEY_BITS-1:0]          key_mem   [MAX_ENTRIES];
    logic [DEPTH_BITS-1:0]        depth_mem [MAX_ENTRIES];
    logic [MOVE_BITS-1:0]         move_mem  [MAX_ENTRIES];
    logic signed [SCORE_BITS-1:0] score_mem [MAX_ENTRIES];
    logic [BOUND_BITS-1:0]        bound_mem [MAX_ENTRIES];

    logic [ENTRIES_BITS-1:0]      entries_cfg;
    logic [BOUNDARY_BITS-1:0]     boundary_cfg;
    lookup_t                      expected_lookups [$];

    function automatic int clip_score(int v);
        int hi;
        hi = (1 << (SCORE_BITS - 1)) - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < -hi - 1)
        begin
            return -hi - 1;
        end
        return v;
    endfunction

    // outward on store, inward on probe; only scores past the boundary move
    function automatic int mate_adjust(int s, int p, bit outward);
        int b;
        int step;
        b = int'(boundary_cfg);
        step = outward ? p : -p;
        if (s > b)
        begin
            return clip_score(s + step);
        end
        if (s < -b)
        begin
            return clip_score(s - step);
        end
        return s;
    endfunction

    function automatic int slot_of_key(logic [KEY_BITS-1:0] key);
        logic [KEY_BITS-1:0] n;
        n = KEY_BITS'(entries_cfg);
        if (n == 0)
        begin
            n = KEY_BITS'(1);
        end
        else if (n > KEY_BITS'(MAX_ENTRIES))
        begin
            n = KEY_BITS'(MAX_ENTRIES);
        end
        return int'(key % n);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        lookup_t want;
        int      slot;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                key_mem[i]   = '0;
                depth_mem[i] = '0;
                move_mem[i]  = '0;
                score_mem[i] = '0;
                bound_mem[i] = '0;
            end
            entries_cfg  = ENTRIES_RESET;
            boundary_cfg = BOUNDARY_RESET;
            expected_lookups.delete();
            mismatches      = 0;
            lookups_waiting = 0;
            lookups_checked = 0;
            hits_checked    = 0;
            stores_seen     = 0;
            clears_seen     = 0;
        end
        else
        begin
            if (cfg_en)
            begin
                if (cfg_index == CFG_ENTRIES)
                begin
                    entries_cfg = cfg_data[ENTRIES_BITS-1:0];
                end
                else if (cfg_index == CFG_BOUNDARY)
                begin
                    boundary_cfg = cfg_data[BOUNDARY_BITS-1:0];
                end
            end

            if (rsp_valid && rsp_ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    $error("probe response with no probe outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    lookups_checked++;
                    if (want.hit)
                    begin
                        hits_checked++;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        mismatches++;
                    end
                    if (found_depth !== want.depth)
                    begin
                        $error("found_depth: expected %0d, got %0d", want.depth, found_depth);
                        mismatches++;
                    end
                    if (found_move !== want.move)
                    begin
                        $error("found_move: expected %0h, got %0h", want.move, found_move);
                        mismatches++;
                    end
                    if (found_score !== want.score)
                    begin
                        $error("found_score: expected %0d, got %0d", want.score, found_score);
                        mismatches++;
                    end
                    if (found_bound !== want.bound)
                    begin
                        $error("found_bound: expected %0d, got %0d", want.bound, found_bound);
                        mismatches++;
                    end
                end
            end

            if (req_valid && req_ready)
            begin
                slot = slot_of_key(position_key);
                case (kind)
                    KIND_PROBE:
                    begin
                        want = '0;
                        if (key_mem[slot] == position_key)
                        begin
                            want.hit   = 1'b1;
                            want.depth = depth_mem[slot];
                            want.move  = move_mem[slot];
                            want.score = SCORE_BITS'(mate_adjust(int'(score_mem[slot]),
                                                                 int'(ply), 1'b0));
                            want.bound = bound_mem[slot];
                        end
                        expected_lookups.push_back(want);
                    end
                    KIND_STORE:
                    begin
                        key_mem[slot]   = position_key;
                        depth_mem[slot] = search_depth;
                        move_mem[slot]  = search_move;
                        score_mem[slot] = SCORE_BITS'(mate_adjust(int'(search_score),
                                                                  int'(ply), 1'b1));
                        bound_mem[slot] = bound_kind;
                        stores_seen++;
                    end
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            key_mem[i] = '0;
                        end
                        clears_seen++;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lookups_waiting = expected_lookups.size();
        end
    end

endmodule

// ----- test/tb_direct_mapped_transposition_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_direct_mapped_transposition_table
// Drives probes, stores and clears into the transposition table with random
// gaps and response stalls, over several index moduli and mate boundaries,
// including a long response hold-off. The checker beside the block predicts
// every probe response; this top decides pass or fail.
// ----------------------------------------------------------------------------

module tb_direct_mapped_transposition_table;
    import dmtt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 280;
    localparam int SCORE_TOP    = (1 << (SCORE_BITS - 1)) - 1;
    localparam int SCORE_BOTTOM = -SCORE_TOP - 1;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_en;
    logic [CFG_INDEX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]     cfg_data;
    logic                         req_valid;
    logic                         req_ready;
    logic [KIND_BITS-1:0]         kind;
    logic [KEY_BITS-1:0]          position_key;
    logic [PLY_BITS-1:0]          ply;
    logic [DEPTH_BITS-1:0]        search_depth;
    logic [MOVE_BITS-1:0]         search_move;
    logic signed [SCORE_BITS-1:0] search_score;
    logic [BOUND_BITS-1:0]        bound_kind;
    logic                         rsp_valid;
    logic                         rsp_ready;
    logic                         hit;
    logic [DEPTH_BITS-1:0]        found_depth;
    logic [MOVE_BITS-1:0]         found_move;
    logic signed [SCORE_BITS-1:0] found_score;
    logic [BOUND_BITS-1:0]        found_bound;

    int                           mismatches;
    int                           lookups_waiting;
    int                           lookups_checked;
    int                           hits_checked;
    int                           stores_seen;
    int                           clears_seen;

    logic [KEY_BITS-1:0]          key_pool [$];
    int                           slots_in_use;
    bit                           send_no_gaps;
    bit                           take_no_gaps;

    int entries_setting  [PHASES] = '{1024, 1, 0, 2047, 13, 31749, 1000};
    int boundary_setting [PHASES] = '{30000, 0, 32767, 100, 31000, 20000, 0};

    direct_mapped_transposition_table dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .kind         (kind),
        .position_key (position_key),
        .ply          (ply),
        .search_depth (search_depth),
        .search_move  (search_move),
        .search_score (search_score),
        .bound_kind   (bound_kind),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .hit          (hit),
        .found_depth  (found_depth),
        .found_move   (found_move),
        .found_score  (found_score),
        .found_bound  (found_bound)
    );

    dmtt_checker score_chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_en          (cfg_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .kind            (kind),
        .position_key    (position_key),
        .ply             (ply),
        .search_depth    (search_depth),
        .search_move     (search_move),
        .search_score    (search_score),
        .bound_kind      (bound_kind),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .hit             (hit),
        .found_depth     (found_depth),
        .found_move      (found_move),
        .found_score     (found_score),
        .found_bound     (found_bound),
        .mismatches      (mismatches),
        .lookups_waiting (lookups_waiting),
        .lookups_checked (lookups_checked),
        .hits_checked    (hits_checked),
        .stores_seen     (stores_seen),
        .clears_seen     (clears_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic issue(
        input logic [KIND_BITS-1:0]         op,
        input logic [KEY_BITS-1:0]          key,
        input logic [PLY_BITS-1:0]          distance,
        input logic [DEPTH_BITS-1:0]        depth,
        input logic [MOVE_BITS-1:0]         move,
        input logic signed [SCORE_BITS-1:0] score,
        input logic [BOUND_BITS-1:0]        bound
    );
        int gap;
        if ($urandom_range(0, 63) == 0)
        begin
            send_no_gaps = !send_no_gaps;
        end
        gap = send_no_gaps ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid    <= 1'b1;
        kind         <= op;
        position_key <= key;
        ply          <= distance;
        search_depth <= depth;
        search_move  <= move;
        search_score <= score;
        bound_kind   <= bound;
        do
            @(posedge clk);
        while (!req_ready);
        if (op == KIND_STORE)
        begin
            key_pool.push_back(key);
            if (key_pool.size() > 48)
            begin
                key_pool.delete(0);
            end
        end
    endtask

    // store fields are don't-care on a probe, so fill them with noise
    task automatic probe(input logic [KEY_BITS-1:0] key, input logic [PLY_BITS-1:0] distance);
        issue(KIND_PROBE, key, distance, DEPTH_BITS'($urandom), MOVE_BITS'($urandom),
              SCORE_BITS'($urandom), BOUND_BITS'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input int value);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(negedge clk);
        cfg_en    <= 1'b0;
    endtask

    // wait for every probe response, then for a full clear to finish
    task automatic settle;
        @(negedge clk);
        req_valid <= 1'b0;
        while (lookups_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int count, input int boundary);
        int                    r;
        int                    v;
        logic [KIND_BITS-1:0]  op;
        logic [KEY_BITS-1:0]   key;
        logic [PLY_BITS-1:0]   distance;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                op = KIND_STORE;
            end
            else if (r < 93)
            begin
                op = KIND_PROBE;
            end
            else if (r < 96)
            begin
                op = KIND_UNUSED;
            end
            else
            begin
                op = KIND_CLEAR;
            end

            // keys: zero, small, same slot as a stored key, a stored key, fresh
            r = $urandom_range(0, 99);
            key = {$urandom, $urandom};
            if (r < 5)
            begin
                key = '0;
            end
            else if (r < 15)
            begin
                key = KEY_BITS'($urandom_range(0, 4095));
            end
            else if (key_pool.size() != 0)
            begin
                if (r < 30)
                begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)]
                          + KEY_BITS'(slots_in_use) * KEY_BITS'($urandom_range(1, 7));
                end
                else if (r < ((op == KIND_PROBE) ? 85 : 45))
                begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
            end

            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                distance = '0;
            end
            else if (r < 30)
            begin
                distance = '1;
            end
            else
            begin
                distance = PLY_BITS'($urandom);
            end

            // scores: anywhere in range, or clustered around the mate boundary, the range ends and zero
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                v = int'($urandom_range(0, 65535)) + SCORE_BOTTOM;
            end
            else if (r < 70)
            begin
                v = boundary + int'($urandom_range(0, 600)) - 300;
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            else if (r < 85)
            begin
                case ($urandom_range(0, 3))
                    0: v = SCORE_TOP;
                    1: v = SCORE_BOTTOM;
                    2: v = SCORE_BOTTOM + 1;
                    default: v = SCORE_TOP - int'($urandom_range(0, 255));
                endcase
            end
            else
            begin
                v = int'($urandom_range(0, 200)) - 100;
            end
            if (v > SCORE_TOP)
            begin
                v = SCORE_TOP;
            end
            if (v < SCORE_BOTTOM)
            begin
                v = SCORE_BOTTOM;
            end

            issue(op, key, distance, DEPTH_BITS'($urandom), MOVE_BITS'($urandom),
                  SCORE_BITS'(v), BOUND_BITS'($urandom));
        end
    endtask

    initial
    begin : response_side
        int gap;
        int taken;
        taken = 0;
        rsp_ready = 1'b0;
        forever
        begin
            // long hold-off so requests back up and the input stalls
            if (taken == 150 || taken == 700)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    rsp_ready <= 1'b0;
                end
            end
            if ($urandom_range(0, 63) == 0)
            begin
                take_no_gaps = !take_no_gaps;
            end
            gap = take_no_gaps ? 0 : $urandom_range(0, 16);
            repeat (gap)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
            taken++;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("** direct_mapped_transposition_table: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int entries;
        int boundary;
        rst_n        = 1'b0;
        cfg_en       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_valid    = 1'b0;
        kind         = KIND_PROBE;
        position_key = '0;
        ply          = '0;
        search_depth = '0;
        search_move  = '0;
        search_score = '0;
        bound_kind   = '0;
        send_no_gaps = 1'b0;
        take_no_gaps = 1'b0;
        slots_in_use = MAX_ENTRIES;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset table: key zero hits an empty slot, all-ones key misses
        probe(64'd0, 8'd0);
        probe('1, 8'd7);
        // saturation at both score ends, with and without ply
        issue(KIND_STORE, '1, 8'd255, 8'hFF, 16'hFFFF, 16'sd32767, 2'd3);
        probe('1, 8'd0);
        probe('1, 8'd255);
        issue(KIND_STORE, 64'h400, 8'd255, 8'h5A, 16'hA5A5, -16'sd32768, 2'd2);
        probe(64'h400, 8'd1);
        // score on the boundary is not a mate score, one past it is
        issue(KIND_STORE, 64'h8000_0000_0000_0005, 8'd10, 8'd1, 16'h0001, 16'sd30000, 2'd1);
        probe(64'h8000_0000_0000_0005, 8'd10);
        issue(KIND_STORE, 64'h8000_0000_0000_0405, 8'd5, 8'd2, 16'h0002, 16'sd30001, 2'd0);
        probe(64'h8000_0000_0000_0005, 8'd5);
        probe(64'h8000_0000_0000_0405, 8'd5);
        issue(KIND_STORE, 64'h1234_5678_9ABC_DEF0, 8'd200, 8'd77, 16'h1234,
              -16'sd30001, 2'd3);
        probe(64'h1234_5678_9ABC_DEF0, 8'd0);
        probe(64'h1234_5678_9ABC_DEF0, 8'd255);
        // unused kind must leave the slot alone
        issue(KIND_UNUSED, 64'h400, 8'd9, 8'h11, 16'h2222, 16'sd1, 2'd1);
        probe(64'h400, 8'd0);
        // clear drops keys only: key zero then sees the old slot data
        issue(KIND_CLEAR, '0, 8'd0, 8'd0, 16'd0, 16'sd0, 2'd0);
        probe(64'd0, 8'd3);
        probe(64'h400, 8'd0);
        probe('1, 8'd0);
        issue(KIND_STORE, 64'd0, 8'd0, 8'd0, 16'd0, 16'sd0, 2'd0);
        probe(64'd0, 8'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            entries  = entries_setting[p];
            boundary = (p == PHASES - 1) ? int'($urandom_range(0, 32767)) : boundary_setting[p];
            settle();
            write_reg(CFG_ENTRIES, entries);
            write_reg(CFG_BOUNDARY, boundary);
            entries = entries & 'h7FF;
            slots_in_use = (entries == 0) ? 1 : (entries > MAX_ENTRIES) ? MAX_ENTRIES : entries;
            random_phase(PHASE_ITEMS, boundary);
        end
        settle();

        $display("covered %0d probes (%0d hits), %0d stores and %0d clears",
                 lookups_checked, hits_checked, stores_seen, clears_seen);
        $display("over %0d modulus/boundary settings with random stalls and a long hold-off",
                 PHASES + 1);
        if (mismatches == 0)
        begin
            $display("** direct_mapped_transposition_table: PASSED **");
        end
        else
        begin
            $display("** direct_mapped_transposition_table: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dmtt_pkg.sv
hdl/dmtt_mod_unit.sv
hdl/dmtt_slot_mem.sv
hdl/direct_mapped_transposition_table.sv
test/dmtt_checker.sv
test/tb_direct_mapped_transposition_table.sv
